FILE: hdl/tlv_summary_stream_parser_defines.svh
// Assertion macros shared by the checker of the TLV summary stream parser.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef TLV_SUMMARY_STREAM_PARSER_DEFINES_SVH
`define TLV_SUMMARY_STREAM_PARSER_DEFINES_SVH

// Implication checked on every rising clock edge, suspended while reset is high.
`define TSSP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Implication checked on every rising clock edge, reset included.
`define TSSP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/tssp_pkg.sv
// Types and codes of the TLV summary stream parser.
// No dependencies; used by the top level and by its checker.
package tssp_pkg;

   localparam int unsigned TAG_PACKSET  = 32'h0000_0001;
   localparam int unsigned TAG_PACK     = 32'h0000_0002;
   localparam int unsigned TAG_MOD      = 32'h0000_0003;
   localparam int unsigned TAG_INSTANCE = 32'h0000_0004;
   localparam int unsigned VALUE_LEN    = 32'd8;

   localparam int unsigned HDR_BYTES    = 8;
   localparam int unsigned TDATA_W      = 72;   // 64-bit value + 2-bit status, byte padded

   // What the bytes of the current payload are
   typedef enum logic [2:0] {
      PK_SKIP     = 3'd0,
      PK_PACKSET  = 3'd1,
      PK_PACK     = 3'd2,
      PK_MOD      = 3'd3,
      PK_INSTANCE = 3'd4
   } payload_kind_type;

   // Result record kinds, carried on rsp_tuser
   typedef enum logic [2:0] {
      REC_PACKSET    = 3'd0,
      REC_PACK       = 3'd1,
      REC_MOD        = 3'd2,
      REC_INST_START = 3'd3,
      REC_INST_BYTE  = 3'd4,
      REC_END        = 3'd5
   } record_kind_type;

   // End-of-blob status codes
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_TRUNC  = 2'd1,
      ST_BADLEN = 2'd2,
      ST_DUP    = 2'd3
   } status_type;

endpackage

FILE: hdl/tlv_summary_stream_parser.sv
// Top level of the TLV summary stream parser: byte-wide tag-length-value parsing.
// Depends on tssp_pkg for record kinds, payload kinds and status codes.
//
// Usage:
//  - req channel: one transaction per blob byte (req_tuser = 0, byte in req_tdata),
//    and one end-of-blob transaction (req_tuser = 1, req_tdata ignored).
//  - Records are a 32-bit LE tag, a 32-bit LE length and a payload. Tags 1..3
//    carry 8-byte values, tag 4 an instance id, any other tag is skipped.
//  - rsp channel: zero or one record per req transaction. rsp_tuser is the
//    record kind, rsp_tdata the value and status, rsp_tlast the last id byte.
//  - Result timing: a result appears on rsp in the cycle after its req transaction.
//  - Throughput: one req transaction per cycle, except during a stall. All parsing
//    of a byte (header byte lane select, tag/length checks, 32-bit length countdown)
//    sits between the state registers and the single result register.
//  - Stall: req_tready drops only while the result register is full and
//    rsp_tready is low; the stalled result holds until taken.
//  - Reset clears all parse state and the result register valid. The end-of-blob
//    transaction also clears all parse state, after reporting the latched
//    status (first error wins; end inside a header or payload is truncation).
module tlv_summary_stream_parser (
   input  logic                         clock,
   input  logic                         reset,
   // input byte stream
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [7:0] data_byte
   input  logic                         req_tuser,   // [0] action: 1 = end of blob
   // result records
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [tssp_pkg::TDATA_W-1:0] rsp_tdata,   // [63:0] value, [65:64] status, zero pad
   output logic                         rsp_tlast,   // [0] id_last
   output logic [2:0]                   rsp_tuser    // [2:0] record_kind
);

   // ---------------------------------------------------------------------
   // Parse state
   // ---------------------------------------------------------------------
   logic                       in_payload_ff,    in_payload_in;
   logic [2:0]                 header_count_ff,  header_count_in;
   logic [63:0]                header_shift_ff,  header_shift_in;
   logic [31:0]                payload_left_ff,  payload_left_in;
   tssp_pkg::payload_kind_type payload_kind_ff,  payload_kind_in;
   logic [63:0]                value_shift_ff,   value_shift_in;
   logic                       seen_packset_ff,  seen_packset_in;
   logic                       seen_instance_ff, seen_instance_in;
   tssp_pkg::status_type       error_code_ff,    error_code_in;

   // Result register
   logic                       rsp_valid_ff,  rsp_valid_in;
   tssp_pkg::record_kind_type  rsp_kind_ff,   rsp_kind_in;
   logic [63:0]                rsp_value_ff,  rsp_value_in;
   logic                       rsp_last_ff,   rsp_last_in;
   tssp_pkg::status_type       rsp_status_ff, rsp_status_in;

   // ---------------------------------------------------------------------
   // Handshake: the result register frees up when empty or being drained
   // ---------------------------------------------------------------------
   logic req_accept;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // Complete header as it will look once the current byte lands
   logic [63:0] header_full;
   logic [31:0] hdr_tag;
   logic [31:0] hdr_len;
   logic        hdr_is_value;
   logic [31:0] left_dec;
   logic [63:0] value_next;

   always_comb begin
      for (int i = 0; i < tssp_pkg::HDR_BYTES; i++) begin
         header_full[8*i +: 8] = (header_count_ff == 3'(i)) ? req_tdata
                                                           : header_shift_ff[8*i +: 8];
      end
   end

   assign hdr_tag      = header_full[31:0];
   assign hdr_len      = header_full[63:32];
   assign hdr_is_value = (hdr_tag == tssp_pkg::TAG_PACKSET) ||
                         (hdr_tag == tssp_pkg::TAG_PACK) ||
                         (hdr_tag == tssp_pkg::TAG_MOD);
   assign left_dec     = payload_left_ff - 32'd1;
   assign value_next   = {req_tdata, value_shift_ff[63:8]};

   // ---------------------------------------------------------------------
   // Next-state and result logic
   // ---------------------------------------------------------------------
   always_comb begin
      in_payload_in    = in_payload_ff;
      header_count_in  = header_count_ff;
      header_shift_in  = header_shift_ff;
      payload_left_in  = payload_left_ff;
      payload_kind_in  = payload_kind_ff;
      value_shift_in   = value_shift_ff;
      seen_packset_in  = seen_packset_ff;
      seen_instance_in = seen_instance_ff;
      error_code_in    = error_code_ff;

      // result register drains on a taken transaction
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      if (req_accept) begin
         // new transaction: no result unless set below
         rsp_valid_in  = 1'b0;
         rsp_value_in  = '0;
         rsp_last_in   = 1'b0;
         rsp_status_in = tssp_pkg::ST_OK;

         if (req_tuser) begin
            // end of blob: report, then clear everything
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = tssp_pkg::REC_END;
            rsp_status_in = error_code_ff;
            if (error_code_ff == tssp_pkg::ST_OK &&
                (in_payload_ff || header_count_ff != 3'd0)) begin
               rsp_status_in = tssp_pkg::ST_TRUNC;
            end
            in_payload_in    = 1'b0;
            header_count_in  = '0;
            header_shift_in  = '0;
            payload_left_in  = '0;
            payload_kind_in  = tssp_pkg::PK_SKIP;
            value_shift_in   = '0;
            seen_packset_in  = 1'b0;
            seen_instance_in = 1'b0;
            error_code_in    = tssp_pkg::ST_OK;
         end else if (error_code_ff != tssp_pkg::ST_OK) begin
            // error latched: bytes are dropped until end of blob
         end else if (!in_payload_ff) begin
            header_count_in = header_count_ff + 3'd1;   // wraps to 0 after byte 7
            header_shift_in = header_full;
            if (header_count_ff == 3'(tssp_pkg::HDR_BYTES - 1)) begin
               header_shift_in = '0;
               value_shift_in  = '0;
               if (hdr_is_value) begin
                  if (hdr_len != tssp_pkg::VALUE_LEN) begin
                     error_code_in = tssp_pkg::ST_BADLEN;
                  end else if (hdr_tag == tssp_pkg::TAG_PACKSET && seen_packset_ff) begin
                     error_code_in = tssp_pkg::ST_DUP;
                  end else begin
                     payload_kind_in = tssp_pkg::payload_kind_type'(hdr_tag[2:0]);
                     payload_left_in = hdr_len;
                     in_payload_in   = 1'b1;
                  end
               end else if (hdr_tag == tssp_pkg::TAG_INSTANCE) begin
                  if (seen_instance_ff) begin
                     error_code_in = tssp_pkg::ST_DUP;
                  end else begin
                     seen_instance_in = 1'b1;
                     payload_kind_in  = tssp_pkg::PK_INSTANCE;
                     payload_left_in  = hdr_len;
                     in_payload_in    = (hdr_len != 32'd0);
                     rsp_valid_in     = 1'b1;
                     rsp_kind_in      = tssp_pkg::REC_INST_START;
                     rsp_value_in     = {32'd0, hdr_len};
                  end
               end else begin
                  // unknown tag: count its payload away
                  payload_kind_in = tssp_pkg::PK_SKIP;
                  payload_left_in = hdr_len;
                  in_payload_in   = (hdr_len != 32'd0);
               end
            end
         end else begin
            payload_left_in = left_dec;
            in_payload_in   = (left_dec != 32'd0);
            case (payload_kind_ff)
               tssp_pkg::PK_PACKSET,
               tssp_pkg::PK_PACK,
               tssp_pkg::PK_MOD: begin
                  value_shift_in = value_next;
                  if (left_dec == 32'd0) begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = value_next;
                     case (payload_kind_ff)
                        tssp_pkg::PK_PACKSET: begin
                           rsp_kind_in     = tssp_pkg::REC_PACKSET;
                           seen_packset_in = 1'b1;
                        end
                        tssp_pkg::PK_PACK: begin
                           rsp_kind_in = tssp_pkg::REC_PACK;
                        end
                        default: begin
                           rsp_kind_in = tssp_pkg::REC_MOD;
                        end
                     endcase
                  end
               end
               tssp_pkg::PK_INSTANCE: begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = tssp_pkg::REC_INST_BYTE;
                  rsp_value_in = {56'd0, req_tdata};
                  rsp_last_in  = (left_dec == 32'd0);
               end
               default: begin
                  // skipped payload byte
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff    <= 1'b0;
         header_count_ff  <= '0;
         header_shift_ff  <= '0;
         payload_left_ff  <= '0;
         payload_kind_ff  <= tssp_pkg::PK_SKIP;
         value_shift_ff   <= '0;
         seen_packset_ff  <= 1'b0;
         seen_instance_ff <= 1'b0;
         error_code_ff    <= tssp_pkg::ST_OK;
         rsp_valid_ff     <= 1'b0;
      end else begin
         in_payload_ff    <= in_payload_in;
         header_count_ff  <= header_count_in;
         header_shift_ff  <= header_shift_in;
         payload_left_ff  <= payload_left_in;
         payload_kind_ff  <= payload_kind_in;
         value_shift_ff   <= value_shift_in;
         seen_packset_ff  <= seen_packset_in;
         seen_instance_ff <= seen_instance_in;
         error_code_ff    <= error_code_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_kind_ff   <= rsp_kind_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(tssp_pkg::TDATA_W - 66){1'b0}}, rsp_status_ff, rsp_value_ff};

endmodule

FILE: hdl/tssp_checker.sv
// Port-level checker for the TLV summary stream parser, bound to its top level.
// Depends on tssp_pkg and on tlv_summary_stream_parser_defines.svh.
`include "tlv_summary_stream_parser_defines.svh"

module tssp_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         req_tuser,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [tssp_pkg::TDATA_W-1:0] rsp_tdata,
   input logic                         rsp_tlast,
   input logic [2:0]                   rsp_tuser
);

   // a stalled result must not change
   `TSSP_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "rsp changed while stalled")

   // nothing comes out right after reset
   `TSSP_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_tvalid, "rsp valid after reset")

   // end of blob always yields an end-status record next cycle
   `TSSP_ASSERT(a_end_reported, req_tvalid && req_tready && req_tuser |=> rsp_tvalid && rsp_tuser == tssp_pkg::REC_END, "end of blob not reported")

   // last flag only on instance id bytes
   `TSSP_ASSERT(a_last_kind, rsp_tvalid && rsp_tlast |-> rsp_tuser == tssp_pkg::REC_INST_BYTE, "tlast on a non id-byte record")

   // status is zero except on end records
   `TSSP_ASSERT(a_status_end, rsp_tvalid && rsp_tuser != tssp_pkg::REC_END |-> rsp_tdata[65:64] == 2'd0, "status set on a non-end record")

endmodule

bind tlv_summary_stream_parser tssp_checker u_tssp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
